>>> hdl/deq_pkg.sv
`default_nettype none
package deq_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int OP_W       = 3;
   localparam int WORD_W     = 32;
   localparam int COUNT_W    = 5;
   localparam int STAT_W     = 2;
   localparam int CMD_W      = 3;

   localparam logic [OP_W-1:0] OP_PUSH_BACK   = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_BACK    = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT   = 3'd3;
   localparam logic [OP_W-1:0] OP_COUNT       = 3'd4;
   localparam logic [OP_W-1:0] OP_ERASE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_ERASE_ALL   = 3'd6;
   localparam logic [OP_W-1:0] OP_CLEAR       = 3'd7;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   localparam logic [CMD_W-1:0] CMD_HOLD       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd5;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [DATA_WIDTH-1:0] value;
   } cell_ctrl_type;

   typedef struct packed {
      logic                  valid;
      logic [DATA_WIDTH-1:0] data;
   } link_type;

   typedef struct packed {
      logic                  any_hit;
      logic [CNT_W-1:0]      hit_count;
      logic [DATA_WIDTH-1:0] front_data;
      logic [DATA_WIDTH-1:0] back_data;
      logic [CAPACITY-1:0]   valid_vec;
   } chain_stat_type;

endpackage
`default_nettype wire

>>> hdl/deq_cell.sv
`default_nettype none
module deq_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire deq_pkg::cell_ctrl_type ctrl,
   input  wire deq_pkg::link_type      left,
   input  wire deq_pkg::link_type      right,
   input  wire logic                   prefix_in,
   output deq_pkg::link_type           self,
   output logic                        hit,
   output logic                        prefix_out
);
   import deq_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  valid_ff, valid_in;

   assign hit        = valid_ff && (data_ff == ctrl.value);
   assign prefix_out = prefix_in | hit;
   assign self       = '{valid: valid_ff, data: data_ff};

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (ctrl.cmd)
         CMD_PUSH_BACK: begin
            if (!valid_ff && left.valid) begin
               data_in  = ctrl.value;
               valid_in = 1'b1;
            end
         end
         CMD_PUSH_FRONT: begin
            data_in  = left.data;
            valid_in = left.valid;
         end
         CMD_POP_BACK: begin
            if (valid_ff && !right.valid) valid_in = 1'b0;
         end
         CMD_POP_FRONT: begin
            data_in  = right.data;
            valid_in = right.valid;
         end
         CMD_ERASE: begin
            if (prefix_out) begin
               data_in  = right.data;
               valid_in = right.valid;
            end
         end
         CMD_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

endmodule
`default_nettype wire

>>> hdl/deq_chain.sv
`default_nettype none
module deq_chain (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire deq_pkg::cell_ctrl_type ctrl,
   output deq_pkg::chain_stat_type     stat
);
   import deq_pkg::*;

   link_type            links [CAPACITY];
   logic [CAPACITY:0]   prefix;
   logic [CAPACITY-1:0] hits;
   logic [CAPACITY-1:0] valids;
   logic [DATA_WIDTH-1:0] back_data;

   assign prefix[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      link_type left_link, right_link;
      if (i == 0) begin : g_head
         assign left_link = '{valid: 1'b1, data: ctrl.value};
      end else begin : g_body
         assign left_link = links[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_link = '{valid: 1'b0, data: '0};
      end else begin : g_inner
         assign right_link = links[i+1];
      end
      deq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left       (left_link),
         .right      (right_link),
         .prefix_in  (prefix[i]),
         .self       (links[i]),
         .hit        (hits[i]),
         .prefix_out (prefix[i+1])
      );
      assign valids[i] = links[i].valid;
   end

   // last valid cell holds the back word
   always_comb begin
      back_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (i == CAPACITY - 1) begin
            if (valids[i]) back_data = back_data | links[i].data;
         end else if (valids[i] && !valids[i+1]) begin
            back_data = back_data | links[i].data;
         end
      end
   end

   assign stat.any_hit    = prefix[CAPACITY];
   assign stat.hit_count  = CNT_W'($countones(hits));
   assign stat.front_data = links[0].data;
   assign stat.back_data  = back_data;
   assign stat.valid_vec  = valids;

endmodule
`default_nettype wire

>>> hdl/deque_with_match_erase_core.sv
`default_nettype none
// Bounded double-ended queue of deq_pkg::CAPACITY words held in a row of cells,
// front in the first cell. Push, pop, count, erase first and clear take effect
// as the request is taken: every cell compares against the request word in
// parallel and loads from its left or right neighbor, so the row shifts or
// closes a gap in one step. Erase all removes one match per cycle through the
// same shift, then waits for a free output slot to give its result; no request
// is taken meanwhile. Each request yields exactly one result from an output
// register; a new request is taken while the previous result is being drained.
module deque_with_match_erase_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [deq_pkg::OP_W-1:0]      req_operation,
   input  wire logic [deq_pkg::WORD_W-1:0]    req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [deq_pkg::WORD_W-1:0]         rsp_data_out,
   output logic [deq_pkg::COUNT_W-1:0]        rsp_match_count,
   output logic                               rsp_found,
   output logic [deq_pkg::COUNT_W-1:0]        rsp_occupancy,
   output logic [deq_pkg::STAT_W-1:0]         rsp_status
);
   import deq_pkg::*;

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_ERASE = 1'b1;

   logic                  state_ff, state_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [CNT_W-1:0]      erased_ff, erased_in;
   logic [DATA_WIDTH-1:0] match_ff, match_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     data_ff, data_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  found_ff, found_in;
   logic [COUNT_W-1:0]    occ_ff, occ_in;
   logic [STAT_W-1:0]     stat_ff, stat_in;

   cell_ctrl_type         ctrl;
   chain_stat_type        cstat;
   logic                  slot_free, accept, full, empty;
   logic [DATA_WIDTH-1:0] req_word;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign full      = (fill_ff == CNT_W'(CAPACITY));
   assign empty     = (fill_ff == '0);
   assign req_word  = DATA_WIDTH'(req_value);

   deq_chain u_chain (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (cstat)
   );

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      erased_in    = erased_ff;
      match_in     = match_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      data_in      = data_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      occ_in       = occ_ff;
      stat_in      = stat_ff;
      ctrl.cmd     = CMD_HOLD;
      ctrl.value   = (state_ff == S_ERASE) ? match_ff : req_word;

      if (state_ff == S_ERASE) begin
         if (cstat.any_hit) begin
            ctrl.cmd  = CMD_ERASE;
            fill_in   = fill_ff - 1'b1;
            erased_in = erased_ff + 1'b1;
         end else if (slot_free) begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            data_in      = '0;
            count_in     = COUNT_W'(erased_ff);
            found_in     = 1'b0;
            occ_in       = COUNT_W'(fill_ff);
            stat_in      = STAT_OK;
         end
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         data_in      = '0;
         count_in     = '0;
         found_in     = 1'b0;
         stat_in      = STAT_OK;
         case (req_operation)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
               if (full) begin
                  stat_in = STAT_FULL;
               end else begin
                  ctrl.cmd = (req_operation == OP_PUSH_BACK) ? CMD_PUSH_BACK
                                                             : CMD_PUSH_FRONT;
                  fill_in  = fill_ff + 1'b1;
               end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
               if (empty) begin
                  stat_in = STAT_EMPTY;
               end else begin
                  ctrl.cmd = (req_operation == OP_POP_BACK) ? CMD_POP_BACK
                                                            : CMD_POP_FRONT;
                  fill_in  = fill_ff - 1'b1;
                  data_in  = WORD_W'((req_operation == OP_POP_BACK) ? cstat.back_data
                                                                    : cstat.front_data);
               end
            end
            OP_COUNT: begin
               count_in = COUNT_W'(cstat.hit_count);
            end
            OP_ERASE_FIRST: begin
               if (cstat.any_hit) begin
                  ctrl.cmd = CMD_ERASE;
                  fill_in  = fill_ff - 1'b1;
                  count_in = COUNT_W'(1);
                  found_in = 1'b1;
               end
            end
            OP_ERASE_ALL: begin
               rsp_valid_in = rsp_valid_ff && !rsp_ready;
               state_in     = S_ERASE;
               erased_in    = '0;
               match_in     = req_word;
            end
            OP_CLEAR: begin
               ctrl.cmd = CMD_CLEAR;
               fill_in  = '0;
            end
            default: begin
            end
         endcase
         occ_in = COUNT_W'(fill_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      erased_ff <= erased_in;
      match_ff  <= match_in;
      data_ff   <= data_in;
      count_ff  <= count_in;
      found_ff  <= found_in;
      occ_ff    <= occ_in;
      stat_ff   <= stat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = data_ff;
   assign rsp_match_count = count_ff;
   assign rsp_found       = found_ff;
   assign rsp_occupancy   = occ_ff;
   assign rsp_status      = stat_ff;

   a_fill_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cstat.valid_vec) == int'(fill_ff))
      else $error("fill level disagrees with valid cells");

   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      ((cstat.valid_vec + 1'b1) & cstat.valid_vec) == '0)
      else $error("valid cells not packed at the front");

   a_erase_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERASE) && cstat.any_hit |=> fill_ff == $past(fill_ff) - 1'b1)
      else $error("erase step did not remove one entry");

   a_found_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found |-> rsp_match_count == COUNT_W'(1))
      else $error("found without a single match");

   a_no_take_in_erase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERASE) |-> !accept)
      else $error("request taken during erase sweep");

endmodule
`default_nettype wire
